### rtl/gdc_pkg.sv
package gdc_pkg;

    // field widths
    localparam int COUNT_W = 23;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DOY_W   = 9;

    // register stages in each conversion path, ahead of the output register
    localparam int NUM_STAGES = 5;

    // commands
    localparam logic CMD_TO_DATE  = 1'b0;
    localparam logic CMD_TO_COUNT = 1'b1;

    // calendar constants
    localparam int EPOCH_SHIFT = 730485;
    localparam int COUNT_MAX   = 2921573;
    localparam int DAYS_400Y   = 146097;
    localparam int DAYS_100Y   = 36524;
    localparam int DAYS_4Y     = 1461;
    localparam int DAYS_1Y     = 365;
    localparam int YEAR_MAX    = 9999;
    localparam int Q400_MAX    = 24;
    localparam int Q4_MAX      = 24;

    // x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT for x below 43690
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;

    localparam logic signed [COUNT_W-1:0] COUNT_LO = COUNT_W'(-EPOCH_SHIFT);
    localparam logic signed [COUNT_W-1:0] COUNT_HI = COUNT_W'(COUNT_MAX);

    localparam logic [DOY_W-1:0] MONTH_START [16] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd0, 9'd0
    };

    // days in the year ahead of the first day of month m
    function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DOY_W-1:0] base;
        base = MONTH_START[m];
        if (m > 4'd2 && leap) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

### rtl/gdc_date_split.sv
module gdc_date_split (
    input  logic                                   aclk,
    input  logic [gdc_pkg::NUM_STAGES-1:0]         stage_en,
    input  logic signed [gdc_pkg::COUNT_W-1:0]     day_count,
    output logic                                   bad,
    output logic [gdc_pkg::YEAR_W-1:0]             out_year,
    output logic [gdc_pkg::MONTH_W-1:0]            out_month,
    output logic [gdc_pkg::DAY_W-1:0]              out_day,
    output logic [gdc_pkg::DOY_W-1:0]              day_of_year,
    output logic                                   leap_year
);
    import gdc_pkg::*;

    // stage 1: shift to day 0 = 0001-01-01
    logic [21:0] n_reg;
    logic        bad1_reg;

    // stage 2: 400 year cycles
    logic [4:0]  q400_reg, q400_next;
    logic [17:0] r400_reg, r400_next;
    logic        bad2_reg;

    // stage 3: centuries
    logic [1:0]  q100_reg, q100_next;
    logic [15:0] r100_reg, r100_next;
    logic [YEAR_W-1:0] yacc3_reg;
    logic        bad3_reg;

    // stage 4: 4 year groups
    logic [4:0]  q4_reg, q4_next;
    logic [10:0] r4_reg, r4_next;
    logic [1:0]  q100_s4_reg;
    logic [YEAR_W-1:0] yacc4_reg;
    logic        bad4_reg;

    // stage 5: years, leap flag
    logic [1:0]  q1_next;
    logic [8:0]  r1_reg, r1_next;
    logic [YEAR_W-1:0] year_reg, year_next;
    logic        leap_reg, leap_next;
    logic        bad5_reg;

    always_comb begin
        logic [22:0] diff;
        q400_next = '0;
        r400_next = n_reg[17:0];
        for (int k = 1; k <= Q400_MAX; k++) begin
            diff = {1'b0, n_reg} - 23'(k * DAYS_400Y);
            if (!diff[22]) begin
                q400_next = 5'(k);
                r400_next = diff[17:0];
            end
        end
    end

    always_comb begin
        logic [18:0] diff;
        q100_next = '0;
        r100_next = r400_reg[15:0];
        for (int k = 1; k <= 3; k++) begin
            diff = {1'b0, r400_reg} - 19'(k * DAYS_100Y);
            if (!diff[18]) begin
                q100_next = 2'(k);
                r100_next = diff[15:0];
            end
        end
    end

    always_comb begin
        logic [16:0] diff;
        q4_next = '0;
        r4_next = r100_reg[10:0];
        for (int k = 1; k <= Q4_MAX; k++) begin
            diff = {1'b0, r100_reg} - 17'(k * DAYS_4Y);
            if (!diff[16]) begin
                q4_next = 5'(k);
                r4_next = diff[10:0];
            end
        end
    end

    always_comb begin
        logic [11:0] diff;
        q1_next = '0;
        r1_next = r4_reg[8:0];
        for (int k = 1; k <= 3; k++) begin
            diff = {1'b0, r4_reg} - 12'(k * DAYS_1Y);
            if (!diff[11]) begin
                q1_next = 2'(k);
                r1_next = diff[8:0];
            end
        end
        year_next = yacc4_reg + {7'd0, q4_reg, 2'b00} + YEAR_W'(q1_next) + 14'd1;
        // last year of a 4 year group, except a century that is not a 400th year
        leap_next = (q1_next == 2'd3) && (q4_reg != 5'(Q4_MAX) || q100_s4_reg == 2'd3);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            n_reg    <= 22'(day_count + EPOCH_SHIFT);
            bad1_reg <= (day_count < COUNT_LO) || (day_count > COUNT_HI);
        end
        if (stage_en[1]) begin
            q400_reg <= q400_next;
            r400_reg <= r400_next;
            bad2_reg <= bad1_reg;
        end
        if (stage_en[2]) begin
            q100_reg  <= q100_next;
            r100_reg  <= r100_next;
            yacc3_reg <= YEAR_W'(q400_reg * 400);
            bad3_reg  <= bad2_reg;
        end
        if (stage_en[3]) begin
            q4_reg      <= q4_next;
            r4_reg      <= r4_next;
            q100_s4_reg <= q100_reg;
            yacc4_reg   <= yacc3_reg + YEAR_W'(q100_reg * 100);
            bad4_reg    <= bad3_reg;
        end
        if (stage_en[4]) begin
            r1_reg   <= r1_next;
            year_reg <= year_next;
            leap_reg <= leap_next;
            bad5_reg <= bad4_reg;
        end
    end

    // month search over the start table
    always_comb begin
        logic [MONTH_W-1:0] m;
        logic [DOY_W-1:0]   off;
        m   = 4'd1;
        off = '0;
        for (int mm = 2; mm <= 12; mm++) begin
            if (month_offset(4'(mm), leap_reg) <= r1_reg) begin
                m   = 4'(mm);
                off = month_offset(4'(mm), leap_reg);
            end
        end
        out_month   = m;
        out_day     = DAY_W'(r1_reg - off + 9'd1);
    end

    assign day_of_year = r1_reg + 9'd1;
    assign out_year    = year_reg;
    assign leap_year   = leap_reg;
    assign bad         = bad5_reg;

endmodule

### rtl/gdc_date_join.sv
module gdc_date_join (
    input  logic                                   aclk,
    input  logic [gdc_pkg::NUM_STAGES-1:0]         stage_en,
    input  logic [gdc_pkg::YEAR_W-1:0]             year,
    input  logic [gdc_pkg::MONTH_W-1:0]            month,
    input  logic [gdc_pkg::DAY_W-1:0]              day,
    output logic                                   bad,
    output logic signed [gdc_pkg::COUNT_W-1:0]     count_out
);
    import gdc_pkg::*;

    // stage 1
    logic [YEAR_W-1:0]  y1_reg;
    logic [MONTH_W-1:0] m1_reg;
    logic [DAY_W-1:0]   d1_reg;
    logic               bad1_reg;

    // stage 2: century quotients of y-1 and y
    logic [YEAR_W-1:0]  p2_reg, p_next;
    logic [YEAR_W-1:0]  y2_reg;
    logic [7:0]         q100p_reg, q100y_reg;
    logic [26:0]        prod_p, prod_y;
    logic [MONTH_W-1:0] m2_reg;
    logic [DAY_W-1:0]   d2_reg;
    logic               bad2_reg;

    // stage 3: days before the year, month offset
    logic [21:0]        base_reg, base_next;
    logic [DOY_W-1:0]   moff_reg;
    logic [DAY_W-1:0]   d3_reg;
    logic               leap_next;
    logic               bad3_reg;

    // stages 4 and 5
    logic signed [COUNT_W-1:0] count4_reg, count5_reg;
    logic               bad4_reg, bad5_reg;

    assign p_next = y1_reg - 14'd1;
    assign prod_p = 27'(p_next) * 27'(DIV100_MUL);
    assign prod_y = 27'(y1_reg) * 27'(DIV100_MUL);

    always_comb begin
        leap_next = (y2_reg[1:0] == 2'b00)
                    && ((YEAR_W'(q100y_reg * 100) != y2_reg) || (q100y_reg[1:0] == 2'b00));
        base_next = 22'(p2_reg * DAYS_1Y) + 22'(p2_reg[YEAR_W-1:2])
                    - 22'(q100p_reg) + 22'(q100p_reg[7:2]);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            y1_reg   <= year;
            m1_reg   <= month;
            d1_reg   <= day;
            bad1_reg <= (year == '0) || (year > YEAR_W'(YEAR_MAX))
                        || (month == '0) || (month > 4'd12);
        end
        if (stage_en[1]) begin
            p2_reg    <= p_next;
            y2_reg    <= y1_reg;
            q100p_reg <= prod_p[DIV100_SHIFT +: 8];
            q100y_reg <= prod_y[DIV100_SHIFT +: 8];
            m2_reg    <= m1_reg;
            d2_reg    <= d1_reg;
            bad2_reg  <= bad1_reg;
        end
        if (stage_en[2]) begin
            base_reg <= base_next;
            moff_reg <= month_offset(m2_reg, leap_next);
            d3_reg   <= d2_reg;
            bad3_reg <= bad2_reg;
        end
        if (stage_en[3]) begin
            count4_reg <= COUNT_W'(int'(base_reg) - EPOCH_SHIFT + int'(moff_reg)
                                   + int'(d3_reg) - 1);
            bad4_reg   <= bad3_reg;
        end
        if (stage_en[4]) begin
            count5_reg <= count4_reg;
            bad5_reg   <= bad4_reg;
        end
    end

    assign count_out = count5_reg;
    assign bad       = bad5_reg;

endmodule

### rtl/gregorian_day_count_converter.sv
// path: an accepted input word loads the first stage at the accepting edge and
// moves through the five path stages plus the output register, which raises
// m_tvalid; words hold in place while m_tready is held low and later stages are full
// throughput: one word per cycle unless m_tready stalls; both directions share one pipeline
// reset: aresetn low clears the stage valid bits and m_tvalid; datapath
// registers are not reset
module gregorian_day_count_converter (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // day_count[22:0], year[36:23], month[40:37], day[45:41]
    input  logic        s_tuser,   // command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // count_out[22:0], out_year[36:23], out_month[40:37],
                                   // out_day[45:41], day_of_year[54:46], leap_year[55]
    output logic        m_tuser    // error
);
    import gdc_pkg::*;

    // per stage valid and command, travel alongside the path registers
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] cmd_reg;
    // stage k may load when it is empty or its word moves on this cycle
    logic [NUM_STAGES:0]   rdy;

    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    // split path outputs (day count to date)
    logic                      split_bad;
    logic [YEAR_W-1:0]         split_year;
    logic [MONTH_W-1:0]        split_month;
    logic [DAY_W-1:0]          split_day;
    logic [DOY_W-1:0]          split_doy;
    logic                      split_leap;

    // join path outputs (date to day count)
    logic                      join_bad;
    logic signed [COUNT_W-1:0] join_count;

    // ready chain, from the output register back to the input
    always_comb begin
        rdy[NUM_STAGES] = !m_tvalid_reg || m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];

    gdc_date_split u_split (
        .aclk        (aclk),
        .stage_en    (rdy[NUM_STAGES-1:0]),
        .day_count   (s_tdata[22:0]),
        .bad         (split_bad),
        .out_year    (split_year),
        .out_month   (split_month),
        .out_day     (split_day),
        .day_of_year (split_doy),
        .leap_year   (split_leap)
    );

    gdc_date_join u_join (
        .aclk      (aclk),
        .stage_en  (rdy[NUM_STAGES-1:0]),
        .year      (s_tdata[36:23]),
        .month     (s_tdata[40:37]),
        .day       (s_tdata[45:41]),
        .bad       (join_bad),
        .count_out (join_count)
    );

    // result select; an out of range operand zeroes every field and flags error
    always_comb begin
        m_tdata_next = '0;
        m_tuser_next = 1'b0;
        unique case (cmd_reg[NUM_STAGES-1])
            CMD_TO_DATE: begin
                if (split_bad) begin
                    m_tuser_next = 1'b1;
                end else begin
                    m_tdata_next[36:23] = split_year;
                    m_tdata_next[40:37] = split_month;
                    m_tdata_next[45:41] = split_day;
                    m_tdata_next[54:46] = split_doy;
                    m_tdata_next[55]    = split_leap;
                end
            end
            CMD_TO_COUNT: begin
                if (join_bad) begin
                    m_tuser_next = 1'b1;
                end else begin
                    m_tdata_next[22:0] = join_count;
                end
            end
            default: begin
                m_tuser_next = 1'b1;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (rdy[NUM_STAGES]) begin
                m_tvalid_reg <= valid_reg[NUM_STAGES-1];
            end
        end
    end

    // command tag and output word
    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            cmd_reg[0] <= s_tuser;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
                cmd_reg[k] <= cmd_reg[k-1];
            end
        end
        if (rdy[NUM_STAGES]) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gdc_pkg::*;

    // calendar arithmetic for the prediction, epoch 2001-01-01 is day 0
    localparam longint EPOCH_OFFSET  = 730485;   // days from 0001-01-01 to the epoch
    localparam longint LAST_COUNT    = 2921573;  // 9999-12-31
    localparam longint CYCLE_DAYS    = 146097;   // one 400 year cycle
    localparam longint CENTURY_DAYS  = 36524;
    localparam longint FOUR_YR_DAYS  = 1461;
    localparam longint YEAR_DAYS     = 365;
    localparam int     DRAIN_CYCLES  = 3 * (NUM_STAGES + 1);

    // one input word, unpacked from tdata and tuser
    typedef struct packed {
        logic               command;
        logic [COUNT_W-1:0] day_count;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } conversion_request_t;

    // one result word
    typedef struct packed {
        logic               error;
        logic [COUNT_W-1:0] count_out;
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [DAY_W-1:0]   out_day;
        logic [DOY_W-1:0]   day_of_year;
        logic               leap_year;
    } calendar_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // day_count, year, month, day, two pad bits
    logic        s_tuser = 1'b0; // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // count_out, out_year, out_month, out_day, day_of_year, leap_year
    logic        m_tuser;        // error

    calendar_result_t pending_results [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int result_index = 0;

    gregorian_day_count_converter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // hard stop in case the pipeline hangs
    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // calendar predictor
    // ---------------------------------------------------------------

    function automatic bit is_leap_year(longint y);
        longint r;
        r = y % 400;
        return (r % 4 == 0) && r != 100 && r != 200 && r != 300;
    endfunction

    // days of the year that lie before the first of month m
    function automatic longint days_before_month(longint m, bit leap);
        longint base;
        case (m)
            2:       base = 31;
            3:       base = 59;
            4:       base = 90;
            5:       base = 120;
            6:       base = 151;
            7:       base = 181;
            8:       base = 212;
            9:       base = 243;
            10:      base = 273;
            11:      base = 304;
            12:      base = 334;
            13:      base = 365;
            default: base = 0;
        endcase
        if (m > 2 && m < 14 && leap) begin
            base = base + 1;
        end
        return base;
    endfunction

    function automatic calendar_result_t predict_conversion(conversion_request_t req);
        calendar_result_t res;
        longint cnt, n, r, q400, q100, q4, q1, y, m, d, p, total;
        bit lp;
        res = '0;
        if (req.command == CMD_TO_DATE) begin
            cnt = longint'($signed(req.day_count));
            if (cnt < -EPOCH_OFFSET || cnt > LAST_COUNT) begin
                res.error = 1'b1;
                return res;
            end
            // peel off 400, 100, 4 and 1 year blocks from 0001-01-01
            n = cnt + EPOCH_OFFSET;
            q400 = n / CYCLE_DAYS;
            r = n % CYCLE_DAYS;
            q100 = r / CENTURY_DAYS;
            if (q100 > 3) q100 = 3;
            r = r - q100 * CENTURY_DAYS;
            q4 = r / FOUR_YR_DAYS;
            r = r - q4 * FOUR_YR_DAYS;
            q1 = r / YEAR_DAYS;
            if (q1 > 3) q1 = 3;
            r = r - q1 * YEAR_DAYS;
            y = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
            lp = is_leap_year(y);
            m = 1;
            while (m < 12 && days_before_month(m + 1, lp) <= r) m++;
            res.out_year    = YEAR_W'(y);
            res.out_month   = MONTH_W'(m);
            res.out_day     = DAY_W'(r - days_before_month(m, lp) + 1);
            res.day_of_year = DOY_W'(r + 1);
            res.leap_year   = lp;
        end else begin
            y = req.year;
            m = req.month;
            d = req.day;
            if (y < 1 || y > 9999 || m < 1 || m > 12) begin
                res.error = 1'b1;
                return res;
            end
            // day is not checked against the month length
            p = y - 1;
            total = p * 365 + p / 4 - p / 100 + p / 400 - EPOCH_OFFSET;
            total = total + days_before_month(m, is_leap_year(y)) + d - 1;
            res.count_out = COUNT_W'(total);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // word builders
    // ---------------------------------------------------------------

    // unused fields carry junk so their bits toggle too
    function automatic conversion_request_t to_date_request(longint cnt);
        conversion_request_t req;
        req.command   = CMD_TO_DATE;
        req.day_count = COUNT_W'(cnt);
        req.year      = YEAR_W'($urandom);
        req.month     = MONTH_W'($urandom);
        req.day       = DAY_W'($urandom);
        return req;
    endfunction

    function automatic conversion_request_t to_count_request(int y, int m, int d);
        conversion_request_t req;
        req.command   = CMD_TO_COUNT;
        req.day_count = COUNT_W'($urandom);
        req.year      = YEAR_W'(y);
        req.month     = MONTH_W'(m);
        req.day       = DAY_W'(d);
        return req;
    endfunction

    // day count of a valid date, to aim the date direction at known points
    function automatic longint count_of_date(int y, int m, int d);
        calendar_result_t res;
        res = predict_conversion(to_count_request(y, m, d));
        return longint'($signed(res.count_out));
    endfunction

    function automatic conversion_request_t random_request();
        int pick;
        pick = $urandom_range(99);
        if ($urandom_range(1) == 0) begin
            // day count to date: mostly in span, some near the ends, some anywhere
            if (pick < 80) begin
                return to_date_request(longint'($urandom_range(3652058)) - EPOCH_OFFSET);
            end else if (pick < 90) begin
                if ($urandom_range(1) == 0) begin
                    return to_date_request(-EPOCH_OFFSET + $urandom_range(400) - 200);
                end
                return to_date_request(LAST_COUNT + $urandom_range(400) - 200);
            end
            return to_date_request(longint'($signed(COUNT_W'($urandom))));
        end
        // date to day count: years mostly valid, centuries favored now and then
        return to_count_request(
            (pick < 75) ? $urandom_range(1, 9999) :
            (pick < 90) ? ($urandom_range(0, 99) * 100 + $urandom_range(0, 1)) :
                          $urandom_range(0, (1 << YEAR_W) - 1),
            ($urandom_range(99) < 88) ? $urandom_range(1, 12) : $urandom_range(15),
            $urandom_range(31));
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // entered just after a rising edge, leaves just after the accepting edge
    task automatic send_word(conversion_request_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.command;
        s_tdata  <= {2'b00, req.day, req.month, req.year, req.day_count};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending until every expected word is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // predict every accepted input word
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            pending_results.push_back(predict_conversion('{
                command:   s_tuser,
                day_count: s_tdata[22:0],
                year:      s_tdata[36:23],
                month:     s_tdata[40:37],
                day:       s_tdata[45:41]}));
        end
    end

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(string field_name, longint got, longint want);
        mismatch_count++;
        $display("mismatch in result %0d, %s: got %0d, expected %0d",
                 result_index, field_name, got, want);
    endtask

    always @(posedge aclk) begin
        calendar_result_t got;
        calendar_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{
                error:       m_tuser,
                count_out:   m_tdata[22:0],
                out_year:    m_tdata[36:23],
                out_month:   m_tdata[40:37],
                out_day:     m_tdata[45:41],
                day_of_year: m_tdata[54:46],
                leap_year:   m_tdata[55]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, error", got.error, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.error !== want.error)
                    report_mismatch("error", got.error, want.error);
                if (got.count_out !== want.count_out)
                    report_mismatch("count_out", $signed(got.count_out),
                                    $signed(want.count_out));
                if (got.out_year !== want.out_year)
                    report_mismatch("out_year", got.out_year, want.out_year);
                if (got.out_month !== want.out_month)
                    report_mismatch("out_month", got.out_month, want.out_month);
                if (got.out_day !== want.out_day)
                    report_mismatch("out_day", got.out_day, want.out_day);
                if (got.day_of_year !== want.day_of_year)
                    report_mismatch("day_of_year", got.day_of_year, want.day_of_year);
                if (got.leap_year !== want.leap_year)
                    report_mismatch("leap_year", got.leap_year, want.leap_year);
            end
            result_index++;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // ends of the supported span, the epoch, leap days and the raw field extremes
    task automatic test_to_date_directed();
        send_word(to_date_request(-EPOCH_OFFSET));            // 0001-01-01
        send_word(to_date_request(-EPOCH_OFFSET - 1));        // just below span
        send_word(to_date_request(LAST_COUNT));               // 9999-12-31
        send_word(to_date_request(LAST_COUNT + 1));           // just above span
        send_word(to_date_request(0));                        // epoch
        send_word(to_date_request(-1));                       // day 366 of 2000
        send_word(to_date_request(-307));                     // 2000-02-29
        send_word(to_date_request((1 << (COUNT_W - 1)) - 1)); // largest field value
        send_word(to_date_request(-(1 << (COUNT_W - 1))));    // most negative
        send_word(to_date_request(count_of_date(2100, 3, 1)));
        send_word(to_date_request(count_of_date(1600, 12, 31)));
        send_word(to_date_request(count_of_date(1900, 2, 28)));
    endtask

    // year and month range checks, leap centuries, unchecked day values
    task automatic test_to_count_directed();
        send_word(to_count_request(0, 1, 1));
        send_word(to_count_request(1, 1, 1));
        send_word(to_count_request(9999, 12, 31));
        send_word(to_count_request(10000, 1, 1));
        send_word(to_count_request((1 << YEAR_W) - 1, 15, 31));
        send_word(to_count_request(2001, 0, 1));
        send_word(to_count_request(2001, 13, 1));
        send_word(to_count_request(2001, 15, 1));
        send_word(to_count_request(2000, 2, 29));
        send_word(to_count_request(2000, 3, 1));
        send_word(to_count_request(1900, 3, 1));
        send_word(to_count_request(2100, 3, 1));
        send_word(to_count_request(2001, 1, 0));     // day zero
        send_word(to_count_request(2001, 2, 31));    // past the end of february
        send_word(to_count_request(2400, 12, 31));
    endtask

    // random mix of both directions; optionally drains halfway through
    task automatic test_random_traffic(int num_words, int send_pct, int recv_pct,
                                       bit drain_midway);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < num_words; i++) begin
            if (drain_midway && i == num_words / 2) begin
                wait_for_results();
            end
            send_word(random_request());
        end
    endtask

    initial begin
        send_idle_pct = 26;
        recv_idle_pct = 86;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_to_date_directed();
        test_to_count_directed();
        test_random_traffic(375, 26, 86, 1'b1);
        test_random_traffic(375, 86, 26, 1'b0);
        test_random_traffic(375, 0, 0, 1'b0);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
